FILE: rtl/bfm_pkg.sv
package bfm_pkg;
  localparam int MaxKernel = 8;
  localparam int MaxWidth  = 8192;
  localparam int LineLen   = MaxWidth + MaxKernel - 1;   // 8199
  localparam int ColW      = 14;
  localparam int KW        = 4;
  localparam int SlotW     = 3;
  localparam int PixW      = 16;
  localparam int CsumW     = 19;
  localparam int TotW      = 22;
  localparam int RowAddrW  = SlotW + ColW;
  localparam int RecipShift = 28;
  localparam int RecipW     = 29;

  localparam logic [1:0] RegKernel = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  // per-item control handed from the sequencer to the datapath
  typedef struct packed {
    logic [PixW-1:0]  pixel;
    logic [ColW-1:0]  col;
    logic [ColW-1:0]  row;
    logic [SlotW-1:0] rslot;
    logic [SlotW-1:0] wslot;
    logic             first_row;
    logic             sub_old;
    logic             first_col;
    logic             sub_win;
    logic             emit;
    logic             row_end;
    logic             frame_end;
    logic [KW-1:0]    k;
  } bfm_ctl_t;

  // ceil(2^28 / (k*k)); (t * recip) >> 28 is floor(t / (k*k)) for any 22-bit t
  function automatic logic [RecipW-1:0] bfm_recip(input logic [KW-1:0] k);
    unique case (k)
      4'd2:    bfm_recip = 29'd67108864;
      4'd3:    bfm_recip = 29'd29826162;
      4'd4:    bfm_recip = 29'd16777216;
      4'd5:    bfm_recip = 29'd10737419;
      4'd6:    bfm_recip = 29'd7456541;
      4'd7:    bfm_recip = 29'd5478275;
      4'd8:    bfm_recip = 29'd4194304;
      default: bfm_recip = 29'd268435456;
    endcase
  endfunction
endpackage

FILE: rtl/bfm_seq.sv
module bfm_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [13:0]            cfg_data,
  input  logic                   take,
  input  logic [15:0]            pixel,
  input  logic                   frame_start,
  output bfm_pkg::bfm_ctl_t      ctl
);
  import bfm_pkg::*;

  logic [3:0]       kreg;
  logic [13:0]      wreg, hreg;
  logic [ColW-1:0]  cpos, rpos;
  logic [KW-1:0]    k;
  logic [ColW-1:0]  w, h, c0, r0, c, r;
  logic             wrap;
  // stored position mod i+1 for every kernel size, so a new size applies at once
  logic [SlotW-1:0] rmod [MaxKernel];
  logic [SlotW-1:0] cmod [MaxKernel];
  logic [SlotW-1:0] rm [MaxKernel];
  logic [SlotW-1:0] cm [MaxKernel];
  logic [SlotW-1:0] ksel;

  function automatic logic [SlotW-1:0] mod_inc(input logic [SlotW-1:0] x,
                                               input logic [KW-1:0] m);
    mod_inc = ({1'b0, x} + 1'b1 == m) ? '0 : x + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    k = (kreg == '0) ? KW'(1) : (kreg > KW'(MaxKernel)) ? KW'(MaxKernel) : kreg;
    w = (wreg == '0) ? ColW'(1) : (wreg > ColW'(LineLen)) ? ColW'(LineLen) : wreg;
    h = (hreg == '0) ? ColW'(1) : hreg;
    c0 = frame_start ? '0 : cpos;
    r0 = frame_start ? '0 : rpos;
    wrap = (c0 >= w);
    if (wrap) begin
      c = '0;
      r = r0 + 1'b1;
    end else begin
      c = c0;
      r = r0;
    end
    if (r >= h) r = '0;
    // row is 0, the stored row or one past it
    for (int i = 0; i < MaxKernel; i++) begin
      rm[i] = (r == '0) ? '0 :
              wrap ? mod_inc(frame_start ? '0 : rmod[i], KW'(i + 1)) :
              (frame_start ? '0 : rmod[i]);
      cm[i] = (c == '0) ? '0 : cmod[i];
    end
    ksel = SlotW'(k - 1'b1);
    ctl.pixel     = pixel;
    ctl.col       = c;
    ctl.row       = r;
    ctl.rslot     = rm[ksel];
    ctl.wslot     = cm[ksel];
    ctl.first_row = (r == '0);
    ctl.sub_old   = (r >= ColW'(k));
    ctl.first_col = (c == '0);
    ctl.sub_win   = (c >= ColW'(k));
    ctl.emit      = (r + 1'b1 >= ColW'(k)) && (c + 1'b1 >= ColW'(k));
    ctl.row_end   = (c + 1'b1 == w);
    ctl.frame_end = (c + 1'b1 == w) && (r + 1'b1 == h);
    ctl.k         = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kreg <= 4'd3;
      wreg <= 14'd8194;
      hreg <= 14'd8194;
      cpos <= '0;
      rpos <= '0;
      for (int i = 0; i < MaxKernel; i++) begin
        rmod[i] <= '0;
        cmod[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegKernel: kreg <= cfg_data[3:0];
          RegWidth:  wreg <= cfg_data;
          RegHeight: hreg <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        if (c + 1'b1 >= w) begin
          cpos <= '0;
          rpos <= (r + 1'b1 >= h) ? '0 : r + 1'b1;
          for (int i = 0; i < MaxKernel; i++) begin
            cmod[i] <= '0;
            rmod[i] <= (r + 1'b1 >= h) ? '0 : mod_inc(rm[i], KW'(i + 1));
          end
        end else begin
          cpos <= c + 1'b1;
          rpos <= r;
          for (int i = 0; i < MaxKernel; i++) begin
            cmod[i] <= mod_inc(cm[i], KW'(i + 1));
            rmod[i] <= rm[i];
          end
        end
      end
    end
  end
endmodule

FILE: rtl/bfm_datapath.sv
module bfm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  bfm_pkg::bfm_ctl_t ctl,
  output logic              busy,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [17:0]       res_data
);
  import bfm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SUM, S_DIV, S_OUT} state_t;

  logic [PixW-1:0]  row_mem [2**RowAddrW];
  logic [CsumW-1:0] col_mem [LineLen];
  logic [PixW-1:0]  old_q;
  logic [CsumW-1:0] csum_q;
  logic [CsumW-1:0] winc [MaxKernel];
  logic [TotW-1:0]  total;
  bfm_ctl_t         cur;
  state_t           state;
  logic [CsumW-1:0] col_new;
  logic [TotW-1:0]  tot_new;
  logic [RecipW-1:0] recip;
  logic [TotW+RecipW-1:0] prod;
  logic [RowAddrW-1:0] addr;

  assign busy  = (state != S_IDLE);
  assign recip = bfm_recip(cur.k);
  assign prod  = (TotW+RecipW)'(total) * (TotW+RecipW)'(recip);
  assign addr  = {cur.rslot, cur.col};

  always_comb begin
    col_new = (cur.first_row ? '0 : csum_q) + CsumW'(cur.pixel);
    if (cur.sub_old) col_new = col_new - CsumW'(old_q);
    tot_new = (cur.first_col ? '0 : total) + TotW'(col_new);
    if (cur.sub_win) tot_new = tot_new - TotW'(winc[cur.wslot]);
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      old_q  <= row_mem[addr];
      csum_q <= col_mem[cur.col];
    end
    if (state == S_SUM) begin
      row_mem[addr]    <= cur.pixel;
      col_mem[cur.col] <= col_new;
    end
  end

  // divide by n*n as a multiply by its reciprocal, the cycle after the update
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      total     <= '0;
      for (int i = 0; i < MaxKernel; i++) winc[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (take) begin
          cur   <= ctl;
          state <= S_READ;
        end
        S_READ: state <= S_SUM;
        S_SUM: begin
          total           <= tot_new;
          winc[cur.wslot] <= col_new;
          state           <= cur.emit ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          res_data  <= {cur.frame_end, cur.row_end, prod[RecipShift +: PixW]};
          res_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: if (res_ready) begin
          res_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/box_filter_mean_unit.sv
// box filter mean unit: n x n moving average over a padded raster image
// s_axis: one pixel item per handshake, tdata = pixel, tuser = frame_start
// m_axis: one mean item per complete window, tdata = mean, tuser[0] =
//   row_end, tuser[1] = frame_end; tlast is not used
// cfg: index 0 kernel_size, 1 padded_width, 2 padded_height, always ready
// an item that completes no window goes through a read of line store and
// column sum memory, then the update; one that completes a window adds a
// state for the multiply by the reciprocal of n*n, then presents the
// result; the block takes no new pixel until it is through with the last
// one; reset clears position, window sums and state, loads kernel 3 and
// size 8194 x 8194; memories keep contents; a stalled receiver holds the
// result and the block stops taking pixels until it is taken
module box_filter_mean_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pixel
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // mean
  output logic [1:0]  m_axis_tuser,   // bit 1 frame_end, bit 0 row_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);
  import bfm_pkg::*;

  bfm_ctl_t    ctl;
  logic        busy, take;
  logic [17:0] res;

  assign s_axis_tready = !busy;
  assign take = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = res[15:0];
  assign m_axis_tuser = res[17:16];

  bfm_seq u_seq (.clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .take, .pixel(s_axis_tdata), .frame_start(s_axis_tuser), .ctl);

  bfm_datapath u_dp (.clk, .rst, .take, .ctl, .busy,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res));
endmodule

FILE: rtl/bfm_checker.sv
module bfm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [1:0] m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  a_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]) else $error("frame_end w/o row_end");
  a_noin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("back to back take");
endmodule

bind box_filter_mean_unit bfm_checker u_chk (.clk, .rst, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tuser);
